// ===== hdl/pters_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pters_pkg
// Shared types and helpers of the periodic task scheduler: the candidate that
// travels along the job cell chain, the command bundle sent to every cell and
// the ranking function used by both scheduling policies.
// ----------------------------------------------------------------------------
package pters_pkg;

  // Widths cover the full parameter ranges (up to 64 job slots, 32 tasks).
  localparam int SLOT_W = 6;
  localparam int TASK_W = 5;
  localparam int TCNT_W = 6;

  localparam logic POLICY_EDF = 1'b0;
  localparam logic POLICY_RM  = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic CFG_POLICY     = 1'b0;
  localparam logic CFG_TASK_COUNT = 1'b1;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [TASK_W-1:0] task_idx;
    logic [15:0]       period;
    logic [31:0]       release_time;
    logic [31:0]       abs_deadline;
    logic [15:0]       job_number;
    logic [15:0]       remaining;
    logic              missed;
  } cand_t;

  typedef struct packed {
    logic              policy;
    logic [31:0]       now;
    logic              mark;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [TASK_W-1:0] wr_task;
    logic [15:0]       wr_job;
    logic [31:0]       wr_deadline;
    logic [15:0]       wr_work;
    logic [15:0]       wr_period;
    logic              ld_en;
    logic [TASK_W-1:0] ld_task;
    logic [15:0]       ld_period;
    logic              run_en;
    logic [SLOT_W-1:0] run_slot;
  } cell_cmd_t;

  // True when job a ranks strictly before job b. Job b always sits in a lower
  // slot, so a full tie keeps b.
  function automatic logic ranks_before(input logic pol, input cand_t a, input cand_t b);
    logic r;
    r = 1'b0;
    if (pol == POLICY_EDF) begin
      if (a.abs_deadline != b.abs_deadline) r = a.abs_deadline < b.abs_deadline;
      else if (a.release_time != b.release_time) r = a.release_time < b.release_time;
      else if (a.task_idx != b.task_idx) r = a.task_idx < b.task_idx;
    end else begin
      if (a.period != b.period) r = a.period < b.period;
      else if (a.task_idx != b.task_idx) r = a.task_idx < b.task_idx;
      else if (a.release_time != b.release_time) r = a.release_time < b.release_time;
    end
    return r;
  endfunction

endpackage

// ===== hdl/periodic_task_edf_rm_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_edf_rm_scheduler_unit
// Periodic task scheduler with earliest deadline first or rate monotonic
// selection, built around a chain of job slot cells.
// ----------------------------------------------------------------------------
// A load item gives no result. A tick item raises done_o after a release step
// for each task in use, a mark step, a scan along the job cell chain and an
// execute step. No new item is taken while a tick is under way (busy high).
// Reset clears all jobs, countdowns, job numbers and the time; no sweep.
// Results cannot be stalled: done_o is high for one cycle per tick item.
module periodic_task_edf_rm_scheduler_unit #(
  parameter int MAX_TASKS = 8,
  parameter int MAX_JOBS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [2:0]  task_slot_i,
  input  logic [15:0] period_i,
  input  logic [15:0] relative_deadline_i,
  input  logic [15:0] execution_time_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] tick_time_o,
  output logic        idle_o,
  output logic [2:0]  running_task_o,
  output logic [15:0] running_job_number_o,
  output logic        job_completed_o,
  output logic        completed_late_o,
  output logic        context_switch_o,
  output logic        preemption_o,
  output logic        release_dropped_o
);
  import pters_pkg::*;

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REL  = 3'd1;
  localparam logic [2:0] ST_MARK = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EXEC = 3'd4;

  localparam logic [1:0] LAST_NONE = 2'd0;
  localparam logic [1:0] LAST_FIN  = 2'd1;
  localparam logic [1:0] LAST_SLOT = 2'd2;

  logic [2:0]        state_q, state_d;
  logic              policy_q;
  logic [3:0]        task_count_q;
  logic [31:0]       time_q;
  logic [TCNT_W-1:0] rel_idx_q;
  logic [SLOT_W:0]   scan_q;
  logic              dropped_q;
  logic [1:0]        last_kind_q;
  logic [SLOT_W-1:0] last_slot_q;

  // Task tables written by loads, with per-task countdowns and job numbers; all read at the release step's task.
  logic [15:0] period_tab_q    [MAX_TASKS];
  logic [15:0] deadline_tab_q  [MAX_TASKS];
  logic [15:0] work_tab_q      [MAX_TASKS];
  logic [15:0] countdown_q     [MAX_TASKS];
  logic [15:0] next_job_q      [MAX_TASKS];

  logic [TCNT_W-1:0] tasks_lim;
  logic [TW-1:0]     ri;
  logic              accept, is_load;
  logic [TW+2:0]     ld_ext;
  logic              ld_ok;
  logic [TW-1:0]     ld_idx;
  logic [MAX_JOBS-1:0] valid_vec;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              rel_fire;
  cell_cmd_t         cmd;
  cand_t             chain_in  [MAX_JOBS];
  cand_t             chain_out [MAX_JOBS];
  cand_t             best;
  logic              completed, late, cs, pre;
  logic [31:0]       now_p1;
  logic [TASK_W+2:0] task_ext;

  assign accept  = start && !busy;
  assign is_load = operation_i == OP_LOAD;
  assign busy    = state_q != ST_IDLE;

  assign tasks_lim = (TCNT_W'(task_count_q) > TCNT_W'(MAX_TASKS)) ? TCNT_W'(MAX_TASKS)
                                                                  : TCNT_W'(task_count_q);
  assign ri        = rel_idx_q[TW-1:0];

  // A load slot beyond the table is ignored.
  assign ld_ext = {TW'(0), task_slot_i};
  assign ld_ok  = ld_ext < (TW+3)'(MAX_TASKS);
  assign ld_idx = ld_ext[TW-1:0];

  // Lowest free job slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = MAX_JOBS - 1; k >= 0; k--) begin
      if (!valid_vec[k]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(k);
      end
    end
  end

  // Task whose countdown is zero releases a job this step.
  assign rel_fire = state_q == ST_REL && countdown_q[ri] == 16'd0;

  assign best   = chain_out[MAX_JOBS-1];
  assign now_p1 = time_q + 32'd1;

  always_comb begin
    completed = best.remaining == 16'd1;
    late      = best.missed || (now_p1 > best.abs_deadline);
    cs        = 1'b0;
    pre       = 1'b0;
    if (last_kind_q == LAST_FIN) begin
      cs = 1'b1;
    end else if (last_kind_q == LAST_SLOT && last_slot_q != best.slot) begin
      cs  = 1'b1;
      pre = 1'b1;
    end
    task_ext = {3'b000, best.task_idx};
  end

  // Command bundle broadcast to every cell.
  always_comb begin
    cmd.policy      = policy_q;
    cmd.now         = time_q;
    cmd.mark        = state_q == ST_MARK;
    cmd.wr_en       = rel_fire && work_tab_q[ri] != 16'd0 && free_found;
    cmd.wr_slot     = free_slot;
    cmd.wr_task     = TASK_W'(rel_idx_q);
    cmd.wr_job      = next_job_q[ri];
    cmd.wr_deadline = time_q + {16'd0, deadline_tab_q[ri]};
    cmd.wr_work     = work_tab_q[ri];
    cmd.wr_period   = period_tab_q[ri];
    cmd.ld_en       = accept && is_load && ld_ok;
    cmd.ld_task     = TASK_W'(ld_ext);
    cmd.ld_period   = period_i;
    cmd.run_en      = state_q == ST_EXEC && best.found;
    cmd.run_slot    = best.slot;
  end

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cells
    if (g == 0) begin : g_head
      assign chain_in[g] = '0;
    end else begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    pters_cell #(
      .SLOT(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .cand_i  (chain_in[g]),
      .cand_o  (chain_out[g]),
      .valid_o (valid_vec[g])
    );
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_load) begin
          state_d = (tasks_lim == '0) ? ST_MARK : ST_REL;
        end
      end
      ST_REL: begin
        if (rel_idx_q == tasks_lim - TCNT_W'(1)) state_d = ST_MARK;
      end
      ST_MARK: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_q == (SLOT_W+1)'(MAX_JOBS - 1)) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      policy_q     <= POLICY_EDF;
      task_count_q <= 4'd1;
      time_q       <= '0;
      rel_idx_q    <= '0;
      scan_q       <= '0;
      dropped_q    <= 1'b0;
      last_kind_q  <= LAST_NONE;
      last_slot_q  <= '0;
      done_o       <= 1'b0;
      for (int t = 0; t < MAX_TASKS; t++) begin
        countdown_q[t] <= '0;
        next_job_q[t]  <= '0;
      end
    end else begin
      state_q <= state_d;
      done_o  <= state_q == ST_EXEC;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POLICY) policy_q <= cfg_wdata_i[0];
        else task_count_q <= cfg_wdata_i;
      end
      if (state_q == ST_IDLE) begin
        rel_idx_q <= '0;
        scan_q    <= '0;
        if (accept && !is_load) dropped_q <= 1'b0;
      end
      if (state_q == ST_REL) begin
        rel_idx_q <= rel_idx_q + TCNT_W'(1);
        if (rel_fire) begin
          countdown_q[ri] <= (period_tab_q[ri] == 16'd0) ? 16'd0 : period_tab_q[ri] - 16'd1;
          next_job_q[ri]  <= next_job_q[ri] + 16'd1;
          if (work_tab_q[ri] != 16'd0 && !free_found) dropped_q <= 1'b1;
        end else begin
          countdown_q[ri] <= countdown_q[ri] - 16'd1;
        end
      end
      if (state_q == ST_SCAN) scan_q <= scan_q + (SLOT_W+1)'(1);
      if (state_q == ST_EXEC) begin
        time_q <= now_p1;
        if (!best.found) begin
          last_kind_q <= LAST_NONE;
        end else if (completed) begin
          last_kind_q <= LAST_FIN;
        end else begin
          last_kind_q <= LAST_SLOT;
          last_slot_q <= best.slot;
        end
      end
    end
  end

  // Task tables and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd.ld_en) begin
      period_tab_q[ld_idx]   <= period_i;
      deadline_tab_q[ld_idx] <= relative_deadline_i;
      work_tab_q[ld_idx]     <= execution_time_i;
    end
    if (state_q == ST_EXEC) begin
      tick_time_o          <= time_q;
      release_dropped_o    <= dropped_q;
      idle_o               <= !best.found;
      running_task_o       <= best.found ? task_ext[2:0] : 3'd0;
      running_job_number_o <= best.found ? best.job_number : 16'd0;
      job_completed_o      <= best.found && completed;
      completed_late_o     <= best.found && completed && late;
      context_switch_o     <= best.found && cs;
      preemption_o         <= best.found && pre;
    end
  end

`ifndef ASSERT_OFF
  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("tick finished without a result");
  a_late_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && completed_late_o |-> job_completed_o) else $error("late without completion");
  a_preempt_is_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && preemption_o |-> context_switch_o) else $error("preemption without switch");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && idle_o |-> !context_switch_o && !job_completed_o)
    else $error("idle tick reports a job");
`endif

endmodule

// ===== hdl/pters_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pters_cell
// One job slot. Holds a pending job, flags a passed deadline, and passes the
// better of its own job and the incoming candidate to the next cell.
// ----------------------------------------------------------------------------
module pters_cell #(
  parameter int SLOT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pters_pkg::cell_cmd_t cmd_i,
  input  pters_pkg::cand_t   cand_i,
  output pters_pkg::cand_t   cand_o,
  output logic               valid_o
);
  import pters_pkg::*;

  logic              valid_q;
  logic [TASK_W-1:0] task_q;
  logic [15:0]       period_q;
  logic [31:0]       release_q;
  logic [31:0]       deadline_q;
  logic [15:0]       job_q;
  logic [15:0]       remaining_q;
  logic              missed_q;
  cand_t             cand_q;
  cand_t             self_c;
  logic              wr_hit, run_hit;

  assign wr_hit  = cmd_i.wr_en && (cmd_i.wr_slot == SLOT_W'(SLOT));
  assign run_hit = cmd_i.run_en && (cmd_i.run_slot == SLOT_W'(SLOT));

  always_comb begin
    self_c.found        = valid_q;
    self_c.slot         = SLOT_W'(SLOT);
    self_c.task_idx     = task_q;
    self_c.period       = period_q;
    self_c.release_time = release_q;
    self_c.abs_deadline = deadline_q;
    self_c.job_number   = job_q;
    self_c.remaining    = remaining_q;
    self_c.missed       = missed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_hit) begin
      valid_q <= 1'b1;
    end else if (run_hit && remaining_q == 16'd1) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      task_q      <= cmd_i.wr_task;
      period_q    <= cmd_i.wr_period;
      release_q   <= cmd_i.now;
      deadline_q  <= cmd_i.wr_deadline;
      job_q       <= cmd_i.wr_job;
      remaining_q <= cmd_i.wr_work;
      missed_q    <= 1'b0;
    end else begin
      if (cmd_i.ld_en && cmd_i.ld_task == task_q) begin
        period_q <= cmd_i.ld_period;
      end
      if (cmd_i.mark && valid_q && cmd_i.now >= deadline_q) begin
        missed_q <= 1'b1;
      end
      if (run_hit) begin
        remaining_q <= remaining_q - 16'd1;
      end
    end
    if (valid_q && (!cand_i.found || ranks_before(cmd_i.policy, self_c, cand_i))) begin
      cand_q <= self_c;
    end else begin
      cand_q <= cand_i;
    end
  end

  assign cand_o  = cand_q;
  assign valid_o = valid_q;

endmodule

// ===== tb/periodic_task_edf_rm_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_edf_rm_scheduler_unit_test
// Self-checking bench for the periodic task scheduler. A scoreboard object
// keeps its own copy of the task table, job slots and time. It predicts the
// result of every accepted tick and compares it field by field with the
// strobed result. Directed loads and ticks come first. Random phases follow,
// and each phase runs with its own policy and task count.
// ----------------------------------------------------------------------------
module periodic_task_edf_rm_scheduler_unit_test;
  import pters_pkg::*;

  localparam int NTASK = 8;
  localparam int NSLOT = 16;
  localparam int RUN_FINISHED = NSLOT;
  localparam int RUN_NONE = NSLOT + 1;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    bit [31:0] tick_time;
    bit        idle;
    bit [2:0]  running_task;
    bit [15:0] running_job_number;
    bit        job_completed;
    bit        completed_late;
    bit        context_switch;
    bit        preemption;
    bit        release_dropped;
  } tick_report_t;

  // Scheduler shadow: it advances one tick per accepted tick item and keeps
  // the reports that the block still owes.
  class sched_scoreboard;
    bit        policy;
    bit [3:0]  task_count;
    bit [15:0] period_tab[NTASK];
    bit [15:0] deadline_tab[NTASK];
    bit [15:0] work_tab[NTASK];
    bit [15:0] countdown[NTASK];
    bit [15:0] job_seq[NTASK];
    bit        busy_slot[NSLOT];
    bit [2:0]  slot_owner[NSLOT];
    bit [15:0] slot_seq[NSLOT];
    bit [31:0] slot_release[NSLOT];
    bit [31:0] slot_deadline[NSLOT];
    bit [15:0] slot_left[NSLOT];
    bit        slot_late[NSLOT];
    bit [31:0] now_tick;
    int        last_slot;
    tick_report_t owed[$];
    int        errors;

    function new();
      policy = POLICY_EDF;
      task_count = 4'd1;
      now_tick = '0;
      last_slot = RUN_NONE;
      errors = 0;
      foreach (countdown[i]) begin
        countdown[i] = '0;
        job_seq[i] = '0;
      end
      foreach (busy_slot[i]) busy_slot[i] = 1'b0;
    endfunction

    function bit outranks(int a, int b);
      bit [15:0] pa, pb;
      pa = period_tab[slot_owner[a]];
      pb = period_tab[slot_owner[b]];
      if (policy == POLICY_EDF) begin
        if (slot_deadline[a] != slot_deadline[b]) return slot_deadline[a] < slot_deadline[b];
        if (slot_release[a] != slot_release[b]) return slot_release[a] < slot_release[b];
        if (slot_owner[a] != slot_owner[b]) return slot_owner[a] < slot_owner[b];
      end else begin
        if (pa != pb) return pa < pb;
        if (slot_owner[a] != slot_owner[b]) return slot_owner[a] < slot_owner[b];
        if (slot_release[a] != slot_release[b]) return slot_release[a] < slot_release[b];
      end
      return a < b;
    endfunction

    function void note_item(bit op, bit [2:0] tsk, bit [15:0] per, bit [15:0] dl,
                            bit [15:0] ex);
      tick_report_t r;
      int ntasks, s, pick;
      bit [15:0] num;
      if (op == OP_LOAD) begin
        period_tab[tsk] = per;
        deadline_tab[tsk] = dl;
        work_tab[tsk] = ex;
        return;
      end
      r = '{default: 0};
      r.tick_time = now_tick;
      ntasks = task_count > NTASK ? NTASK : task_count;
      for (int t = 0; t < ntasks; t++) begin
        if (countdown[t] != 0) begin
          countdown[t] = countdown[t] - 16'd1;
          continue;
        end
        countdown[t] = period_tab[t] == 0 ? 16'd0 : period_tab[t] - 16'd1;
        num = job_seq[t];
        job_seq[t] = num + 16'd1;
        if (work_tab[t] == 0) continue;
        for (s = 0; s < NSLOT; s++) if (!busy_slot[s]) break;
        if (s == NSLOT) begin
          r.release_dropped = 1'b1;
          continue;
        end
        busy_slot[s] = 1'b1;
        slot_owner[s] = 3'(t);
        slot_seq[s] = num;
        slot_release[s] = now_tick;
        slot_deadline[s] = now_tick + 32'(deadline_tab[t]);
        slot_left[s] = work_tab[t];
        slot_late[s] = 1'b0;
      end
      pick = NSLOT;
      for (s = 0; s < NSLOT; s++) begin
        if (!busy_slot[s]) continue;
        if (now_tick >= slot_deadline[s]) slot_late[s] = 1'b1;
        if (pick == NSLOT || outranks(s, pick)) pick = s;
      end
      if (pick == NSLOT) begin
        r.idle = 1'b1;
        last_slot = RUN_NONE;
      end else begin
        if (last_slot == RUN_FINISHED) begin
          r.context_switch = 1'b1;
        end else if (last_slot < NSLOT && last_slot != pick) begin
          r.context_switch = 1'b1;
          r.preemption = 1'b1;
        end
        r.running_task = slot_owner[pick];
        r.running_job_number = slot_seq[pick];
        slot_left[pick] = slot_left[pick] - 16'd1;
        if (slot_left[pick] == 0) begin
          r.job_completed = 1'b1;
          r.completed_late = slot_late[pick] || (now_tick + 32'd1) > slot_deadline[pick];
          busy_slot[pick] = 1'b0;
          last_slot = RUN_FINISHED;
        end else begin
          last_slot = pick;
        end
      end
      now_tick = now_tick + 32'd1;
      owed = {owed, r};
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(tick_report_t got);
      tick_report_t e;
      if (owed.size() == 0) begin
        $error("tick result at time %0d with no tick outstanding", got.tick_time);
        errors++;
        return;
      end
      e = owed.pop_front();
      compare("tick_time", e.tick_time, got.tick_time);
      compare("idle", e.idle, got.idle);
      compare("running_task", e.running_task, got.running_task);
      compare("running_job_number", e.running_job_number, got.running_job_number);
      compare("job_completed", e.job_completed, got.job_completed);
      compare("completed_late", e.completed_late, got.completed_late);
      compare("context_switch", e.context_switch, got.context_switch);
      compare("preemption", e.preemption, got.preemption);
      compare("release_dropped", e.release_dropped, got.release_dropped);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        operation_i;
  logic [2:0]  task_slot_i;
  logic [15:0] period_i;
  logic [15:0] relative_deadline_i;
  logic [15:0] execution_time_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [3:0]  cfg_wdata_i;
  logic        done_o;
  logic [31:0] tick_time_o;
  logic        idle_o;
  logic [2:0]  running_task_o;
  logic [15:0] running_job_number_o;
  logic        job_completed_o;
  logic        completed_late_o;
  logic        context_switch_o;
  logic        preemption_o;
  logic        release_dropped_o;

  sched_scoreboard sb = new();
  int quiet_cycles;
  int burst_left;

  periodic_task_edf_rm_scheduler_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both monitors sample at the rising edge, before the edge's updates land.
  // An item is taken when start is high and busy is low; a result when
  // done_o is high. The watchdog restarts on either.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_item(operation_i, task_slot_i, period_i, relative_deadline_i,
                   execution_time_i);
    if (rst_ni && done_o)
      sb.check_result('{tick_time_o, idle_o, running_task_o, running_job_number_o,
                        job_completed_o, completed_late_o, context_switch_o,
                        preemption_o, release_dropped_o});
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("periodic_task_edf_rm_scheduler_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the block takes it. Start is left
  // high, so a burst runs back to back.
  task automatic send_item(bit op, bit [2:0] tsk, bit [15:0] per, bit [15:0] dl,
                           bit [15:0] ex);
    start <= 1'b1;
    operation_i <= op;
    task_slot_i <= tsk;
    period_i <= per;
    relative_deadline_i <= dl;
    execution_time_i <= ex;
    do @(posedge clk_i); while (busy);
  endtask

  // Bursts of random length, separated by gaps of random length.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    gap = $urandom_range(1, 30);
    start <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Let every owed tick come back. A load gives no result, so a fixed margin
  // follows before the registers change.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The write enable is dropped before the task's final wait, so writes
  // in a row never drive it twice in the same step.
  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) sb.policy = val[0];
    else sb.task_count = val;
    @(posedge clk_i);
  endtask

  // Most loads use short periods and little work, so that jobs pile up,
  // deadlines are missed and slots overflow. A few use full-range values.
  task automatic random_item();
    bit [15:0] per, dl, ex;
    per = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 14));
    dl = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16));
    ex = $urandom_range(0, 40) == 0 ? 16'($urandom_range(0, 400)) :
         16'($urandom_range(0, 4));
    if ($urandom_range(0, 99) < 15)
      send_item(OP_LOAD, 3'($urandom), per, dl, ex);
    else
      send_item(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    bit [3:0] counts[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd9};
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_TICK;
    task_slot_i = '0;
    period_i = '0;
    relative_deadline_i = '0;
    execution_time_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_POLICY;
    cfg_wdata_i = '0;
    quiet_cycles = 0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Every table entry is written before any tick can reach
    // it. The loads cover a zero period, full-range period, deadline and work,
    // a zero deadline and a job with no work.
    send_item(OP_LOAD, 3'd0, 16'd0, 16'd0, 16'd1);
    send_item(OP_LOAD, 3'd1, 16'd65535, 16'd65535, 16'd65535);
    send_item(OP_LOAD, 3'd2, 16'd3, 16'd2, 16'd0);
    send_item(OP_LOAD, 3'd3, 16'd2, 16'd1, 16'd3);
    send_item(OP_LOAD, 3'd4, 16'd1, 16'd0, 16'd2);
    send_item(OP_LOAD, 3'd5, 16'd4, 16'd4, 16'd1);
    send_item(OP_LOAD, 3'd6, 16'd5, 16'd9, 16'd4);
    send_item(OP_LOAD, 3'd7, 16'hAAAA, 16'h5555, 16'd2);
    repeat (3) send_item(OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(CFG_TASK_COUNT, 4'd8);
    repeat (6) send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    drain();
    write_reg(CFG_POLICY, {3'b000, POLICY_RM});
    // A load while the tasks run leaves the countdowns as they are.
    send_item(OP_LOAD, 3'd1, 16'd2, 16'd3, 16'd1);
    repeat (6) send_item(OP_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    drain();

    // Random phases, each with its own policy and task count, the extremes
    // among them.
    foreach (counts[p]) begin
      write_reg(CFG_POLICY, {3'b000, (p % 2 == 0) ? POLICY_EDF : POLICY_RM});
      write_reg(CFG_TASK_COUNT, counts[p]);
      repeat (150) begin
        random_item();
        pace_sender();
      end
      drain();
    end

    if (sb.owed.size() != 0) begin
      $error("%0d tick results never arrived", sb.owed.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("periodic_task_edf_rm_scheduler_unit regression: pass");
    end else begin
      $display("periodic_task_edf_rm_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule
